// File: src/sur_pkg.sv
// Package for the single-pin ultrasonic ranger.
// Constants and the result record used by sur_core and the top level.
`default_nettype none

package sur_pkg;

    localparam int SUR_COUNT_BITS = 20;

    localparam int                     SUR_TIMEOUT_W     = 20;
    localparam logic [SUR_TIMEOUT_W-1:0] SUR_TIMEOUT_RESET = 20'd100000;

    localparam logic [3:0] SUR_LOW_TICKS  = 4'd2;
    localparam logic [3:0] SUR_HIGH_TICKS = 4'd10;

    // 0.0172 cm per tick in Q8: (w * 1127) >> 8
    localparam int          SUR_MUL_W      = 11;
    localparam logic [10:0] SUR_DIST_MUL   = 11'd1127;
    localparam int          SUR_DIST_SHIFT = 8;
    localparam int          SUR_DIST_W     = 23;
    localparam logic [SUR_DIST_W-1:0] SUR_DIST_MAX = 23'h7FFFFF;

    localparam int SUR_TDATA_W = 32;

    typedef struct packed {
        logic                  timed_out;
        logic [SUR_DIST_W-1:0] distance_cm_q8;
        logic                  distance_valid;
        logic                  pin_drive_level;
        logic                  pin_drive_enable;
    } sur_result_t;

endpackage

`default_nettype wire

// File: src/sur_dist.sv
// Echo width to distance conversion: multiply by 1127, drop 8 bits, saturate.
// Depends on sur_pkg.
`default_nettype none

module sur_dist
    import sur_pkg::*;
#(
    parameter int COUNT_BITS = SUR_COUNT_BITS
) (
    input  wire logic [COUNT_BITS-1:0] echo_width,
    output logic      [SUR_DIST_W-1:0] distance
);

    localparam int PROD_W = COUNT_BITS + SUR_MUL_W;
    localparam int SH_W   = PROD_W - SUR_DIST_SHIFT;
    localparam int DW     = (SH_W > SUR_DIST_W) ? SH_W : SUR_DIST_W;

    logic [PROD_W-1:0] prod;
    logic [DW-1:0]     dist_ext;

    always_comb begin
        prod     = PROD_W'(echo_width) * PROD_W'(SUR_DIST_MUL);
        dist_ext = DW'(prod >> SUR_DIST_SHIFT);
        if (dist_ext > DW'(SUR_DIST_MAX)) begin
            distance = SUR_DIST_MAX;
        end else begin
            distance = dist_ext[SUR_DIST_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: src/sur_core.sv
// Ranger sequencer: trigger pulse, listen, echo width count and timeout.
// Holds all measurement state; one step per accepted word. Uses sur_pkg, sur_dist.
`default_nettype none

module sur_core
    import sur_pkg::*;
#(
    parameter int COUNT_BITS = SUR_COUNT_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step_en,
    input  wire logic                     level,
    input  wire logic [SUR_TIMEOUT_W-1:0] timeout_ticks,
    output sur_result_t                   result
);

    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_LISTEN = 2'd2;

    localparam int CMP_W = (COUNT_BITS > SUR_TIMEOUT_W) ? COUNT_BITS : SUR_TIMEOUT_W;

    logic [1:0]            phase_reg, phase_next;
    logic [3:0]            count_reg, count_next;
    logic [COUNT_BITS-1:0] age_reg, age_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic                  rise_reg, rise_next;
    logic                  prev_reg, prev_next;
    logic [SUR_DIST_W-1:0] dist_reg, dist_next;

    logic [SUR_DIST_W-1:0] dist_calc;
    logic                  rising, falling;

    sur_dist #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dist (
        .echo_width(width_reg),
        .distance  (dist_calc)
    );

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        age_next   = age_reg;
        width_next = width_reg;
        rise_next  = rise_reg;
        prev_next  = prev_reg;
        dist_next  = dist_reg;
        result     = '0;
        rising     = level && !prev_reg;
        falling    = !level && prev_reg && rise_reg;

        unique case (phase_reg)
            PH_HIGH: begin
                result.pin_drive_enable = 1'b1;
                result.pin_drive_level  = 1'b1;
                count_next = count_reg + 4'd1;
                if (count_next >= SUR_HIGH_TICKS) begin
                    // release: pin is pulled down, so the edge history starts over
                    phase_next = PH_LISTEN;
                    count_next = '0;
                    age_next   = '0;
                    width_next = '0;
                    rise_next  = 1'b0;
                    prev_next  = 1'b0;
                end
            end
            PH_LISTEN: begin
                age_next = (age_reg == '1) ? age_reg : age_reg + 1'b1;
                if (rising) begin
                    rise_next  = 1'b1;
                    width_next = COUNT_BITS'(1);
                end else if (level && rise_reg) begin
                    width_next = (width_reg == '1) ? width_reg : width_reg + 1'b1;
                end
                prev_next = level;
                // echo beats timeout on the same tick
                if (falling) begin
                    dist_next             = dist_calc;
                    result.distance_valid = 1'b1;
                    phase_next            = PH_LOW;
                    count_next            = '0;
                end else if (CMP_W'(age_next) > CMP_W'(timeout_ticks)) begin
                    result.timed_out = 1'b1;
                    phase_next       = PH_LOW;
                    count_next       = '0;
                end
            end
            default: begin
                // drive low, also taken by the spare code
                phase_next = PH_LOW;
                result.pin_drive_enable = 1'b1;
                count_next = count_reg + 4'd1;
                if (count_next >= SUR_LOW_TICKS) begin
                    phase_next = PH_HIGH;
                    count_next = '0;
                end
            end
        endcase

        result.distance_cm_q8 = dist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOW;
            count_reg <= '0;
            age_reg   <= '0;
            width_reg <= '0;
            rise_reg  <= 1'b0;
            prev_reg  <= 1'b0;
            dist_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            age_reg   <= age_next;
            width_reg <= width_next;
            rise_reg  <= rise_next;
            prev_reg  <= prev_next;
            dist_reg  <= dist_next;
        end
    end

endmodule

`default_nettype wire

// File: src/single_pin_ultrasonic_ranger.sv
// Top level of the single-pin ultrasonic ranger: input, output and timeout registers.
// Depends on sur_pkg and sur_core.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-------------------------------------
//  s_        | in  | s_tvalid / s_tready | echo_level, one word per tick
//  m_        | out | m_tvalid / m_tready | drive enable/level, distance, timeout
//  cfg_      | in  | cfg_valid/cfg_ready | timeout_ticks
//
// One result word per input word; a word enters every cycle while the m_ side takes results.
// The path runs through the input register, then the sequencer step into the output register.
// The sequencer update and the 20x11 multiply are combinational.
// Reset (aresetn low, synchronous) empties both registers and starts a trigger pulse.
// A stalled m_ side holds the output word; the input register keeps one more word.
`default_nettype none

module single_pin_ultrasonic_ranger
    import sur_pkg::*;
#(
    parameter int COUNT_BITS = SUR_COUNT_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [0] echo_level

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [0] pin_drive_enable, [1] pin_drive_level, [2] distance_valid,
    // [25:3] distance_cm_q8, [26] timed_out
    output logic [SUR_TDATA_W-1:0]        m_tdata,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [SUR_TIMEOUT_W-1:0] cfg_data
);

    logic                     in_valid_reg, in_valid_next;
    logic                     in_level_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [SUR_TDATA_W-1:0]   out_data_reg;
    logic [SUR_TIMEOUT_W-1:0] timeout_reg;

    logic        advance;
    sur_result_t step_result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    sur_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .level        (in_level_reg),
        .timeout_ticks(timeout_reg),
        .result       (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= SUR_TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // payload words, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (advance) begin
            out_data_reg <= SUR_TDATA_W'(step_result);
        end
    end

endmodule

`default_nettype wire
